>>> design/bpsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bpsp_pkg
// Shared types and constants of the brush preset stream parser.
// -----------------------------------------------------------------------------
package bpsp_pkg;

  localparam logic [15:0] MagicWord   = 16'h3842;
  localparam logic [31:0] TagMHi      = 32'h6D000000;
  localparam logic [31:0] TagMLo      = 32'h0000006D;
  localparam logic [15:0] MaxCountRst = 16'd10000;
  localparam logic [15:0] MaxNameRst  = 16'd1000;
  localparam logic [31:0] CapSpacing  = 32'd1000;
  localparam logic [31:0] CapDiameter = 32'd2000;
  localparam logic [31:0] CapAngle    = 32'd359;
  localparam logic [31:0] CapPercent  = 32'd100;

  // Result queue entries; keep a power of two so the pointers wrap cleanly.
  localparam int QueueDepth = 8;

  localparam logic CfgMaxCount = 1'b0;
  localparam logic CfgMaxName  = 1'b1;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_PRESET = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ERR_MAGIC    = 4'd0,
    ERR_EOF_VER  = 4'd1,
    ERR_VERSION  = 4'd2,
    ERR_EOF_CNT  = 4'd3,
    ERR_CNT_BIG  = 4'd4,
    ERR_V9       = 4'd5,
    ERR_EOF_TAG  = 4'd6,
    ERR_EOF_LEN  = 4'd7,
    ERR_EOF_BODY = 4'd8,
    ERR_NAME_LEN = 4'd9,
    ERR_OVERREAD = 4'd10
  } err_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] name_unit;
    logic [15:0] brush_number;
    logic [9:0]  spacing;
    logic [10:0] diameter;
    logic [6:0]  hardness;
    logic [8:0]  angle;
    logic [6:0]  roundness;
    logic        long_form;
    logic [3:0]  version;
    logic [3:0]  error_code;
    logic        last;
  } result_t;

  localparam int ResultW = $bits(result_t);

endpackage
`default_nettype wire

>>> design/bpsp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bpsp_front
// Parses one byte a cycle while step_i is high and produces up to two result transactions per byte.
// -----------------------------------------------------------------------------
module bpsp_front import bpsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        final_byte_i,
  input  wire logic [15:0] max_count_i,
  input  wire logic [15:0] max_name_i,
  output result_t          res0_o,
  output result_t          res1_o,
  output logic [1:0]       nres_o
);

  typedef enum logic [15:0] {
    PH_MAGIC   = 16'h0001, PH_VERSION = 16'h0002, PH_UNK   = 16'h0004,
    PH_COUNT   = 16'h0008, PH_TAG     = 16'h0010, PH_LEN   = 16'h0020,
    PH_UNK1    = 16'h0040, PH_NAMELEN = 16'h0080, PH_NAME  = 16'h0100,
    PH_SHORT   = 16'h0200, PH_SPACING = 16'h0400, PH_DIAM  = 16'h0800,
    PH_HARD    = 16'h1000, PH_ANGLE   = 16'h2000, PH_ROUND = 16'h4000,
    PH_SKIP    = 16'h8000
  } phase_e;

  phase_e      ph_q, ph_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] sh_q, sh_d;
  logic [3:0]  ver_q, ver_d;
  logic [15:0] left_q, left_d, idx_q, idx_d, nul_q, nul_d;
  logic [31:0] len_q, len_d;
  logic [32:0] off_q, off_d;
  logic        sf_q, sf_d, fin_q, fin_d, ctag_q, ctag_d;
  logic [9:0]  hs_sp_q, hs_sp_d;
  logic [10:0] hs_di_q, hs_di_d;
  logic [6:0]  hs_ha_q, hs_ha_d;
  logic [8:0]  hs_an_q, hs_an_d;

  result_t    r0, r1;
  logic [1:0] n;

  function automatic logic [31:0] cap(input logic [31:0] v, input logic [31:0] c);
    return (v > c) ? c : v;
  endfunction

  always_comb begin
    logic [31:0] v;
    logic [1:0]  need;
    logic [3:0]  ecode;
    result_t     row;
    logic        fdone;
    logic [31:0] rnd;
    logic [31:0] capv;
    ph_d = ph_q; cnt_d = cnt_q; sh_d = sh_q; ver_d = ver_q; left_d = left_q;
    idx_d = idx_q; nul_d = nul_q; len_d = len_q; off_d = off_q; sf_d = sf_q;
    fin_d = fin_q; ctag_d = ctag_q; hs_sp_d = hs_sp_q; hs_di_d = hs_di_q;
    hs_ha_d = hs_ha_q; hs_an_d = hs_an_q;
    r0 = '0; r1 = '0; n = 2'd0;
    v = '0; need = 2'd3; ecode = ERR_MAGIC; row = '0; fdone = 1'b0; rnd = '0;
    capv = '0;

    // Emit helpers are inlined below; rows pick up current index and version.
    if (step_i && !fin_q) begin
      if (ph_q == PH_UNK1 || ph_q == PH_NAMELEN || ph_q == PH_NAME || ph_q == PH_SHORT ||
          ph_q == PH_SPACING || ph_q == PH_DIAM || ph_q == PH_HARD ||
          ph_q == PH_ANGLE || ph_q == PH_ROUND || ph_q == PH_SKIP)
        off_d = off_q + 33'd1;
      if (ph_q == PH_SKIP) begin
        if (off_d >= {1'b0, len_q}) begin
          left_d = left_q - 16'd1; idx_d = idx_q + 16'd1;
          if (left_d == '0) begin
            row = '0; row.kind = KIND_DONE; row.brush_number = idx_d; row.version = ver_q;
            r0 = row; n = 2'd1; fin_d = 1'b1;
          end else ph_d = PH_TAG;
        end
      end else begin
        if (ph_q == PH_MAGIC || ph_q == PH_VERSION || ph_q == PH_NAME) need = 2'd1;
        sh_d = {sh_q[23:0], data_byte_i};
        if (cnt_q < need) cnt_d = cnt_q + 2'd1;
        else begin
          v = sh_d; cnt_d = '0; sh_d = '0; fdone = 1'b1;
        end
      end
      if (fdone) begin
        row = '0; row.brush_number = idx_q; row.version = ver_q;
        unique case (ph_q)
          PH_MAGIC: begin
            if (v[15:0] != MagicWord) begin
              row.kind = KIND_ERROR; row.error_code = ERR_MAGIC; r0 = row; n = 2'd1;
              fin_d = 1'b1;
            end else ph_d = PH_VERSION;
          end
          PH_VERSION: begin
            if (v[15:0] != 16'd6 && v[15:0] != 16'd7 && v[15:0] != 16'd9) begin
              row.kind = KIND_ERROR; row.error_code = ERR_VERSION; r0 = row; n = 2'd1;
              fin_d = 1'b1;
            end else begin
              ver_d = v[3:0]; ph_d = PH_UNK;
            end
          end
          PH_UNK: ph_d = PH_COUNT;
          PH_COUNT: begin
            if (v > {16'd0, max_count_i}) begin
              row.kind = KIND_ERROR; row.error_code = ERR_CNT_BIG; r0 = row; n = 2'd1;
              fin_d = 1'b1;
            end else if (ver_q == 4'd9) begin
              row.kind = KIND_ERROR; row.error_code = ERR_V9; r0 = row; n = 2'd1;
              fin_d = 1'b1;
            end else begin
              left_d = v[15:0]; idx_d = '0;
              if (v == '0) begin
                row.kind = KIND_DONE; row.brush_number = '0; r0 = row; n = 2'd1;
                fin_d = 1'b1;
              end else ph_d = PH_TAG;
            end
          end
          PH_TAG: begin
            ctag_d = (v == TagMHi) || (v == TagMLo);
            ph_d = PH_LEN;
          end
          PH_LEN: begin
            len_d = v; off_d = '0; ctag_d = 1'b0;
            if (ctag_q) ph_d = PH_UNK1;
            else if (v == '0) begin
              left_d = left_q - 16'd1; idx_d = idx_q + 16'd1;
              if (left_d == '0) begin
                row.kind = KIND_DONE; row.brush_number = idx_d; r0 = row; n = 2'd1;
                fin_d = 1'b1;
              end else ph_d = PH_TAG;
            end else ph_d = PH_SKIP;
          end
          PH_UNK1: ph_d = PH_NAMELEN;
          PH_NAMELEN: begin
            if (v < 32'd1 || v > {16'd0, max_name_i}) begin
              row.kind = KIND_ERROR; row.error_code = ERR_NAME_LEN; r0 = row; n = 2'd1;
              fin_d = 1'b1;
            end else begin
              nul_d = v[15:0]; ph_d = PH_NAME;
            end
          end
          PH_NAME: begin
            row.kind = KIND_NAME; row.name_unit = v[15:0]; r0 = row; n = 2'd1;
            nul_d = nul_q - 16'd1;
            if (nul_d == '0) ph_d = PH_SHORT;
          end
          PH_SHORT: begin
            sf_d = (v != '0); ph_d = PH_SPACING;
          end
          PH_SPACING: begin
            capv = cap(v, CapSpacing);
            hs_sp_d = capv[9:0]; ph_d = PH_DIAM;
          end
          PH_DIAM: begin
            capv = cap(v, CapDiameter);
            hs_di_d = (v == '0) ? 11'd1 : capv[10:0]; ph_d = PH_HARD;
          end
          PH_HARD, PH_ROUND: begin
            capv = cap(v, CapPercent);
            if (ph_q == PH_HARD) hs_ha_d = capv[6:0];
            if (ph_q == PH_HARD && !sf_q) ph_d = PH_ANGLE;
            else begin
              rnd = capv;
              row.kind = KIND_PRESET; row.spacing = hs_sp_q; row.diameter = hs_di_q;
              row.hardness = hs_ha_d;
              if (!sf_q) begin
                row.angle = hs_an_q; row.roundness = rnd[6:0]; row.long_form = 1'b1;
              end
              r0 = row; n = 2'd1;
              if (off_d > {1'b0, len_q}) begin
                row = '0; row.kind = KIND_ERROR; row.error_code = ERR_OVERREAD;
                row.brush_number = idx_q; row.version = ver_q;
                r1 = row; n = 2'd2; fin_d = 1'b1;
              end else if (off_d < {1'b0, len_q}) ph_d = PH_SKIP;
              else begin
                left_d = left_q - 16'd1; idx_d = idx_q + 16'd1;
                hs_sp_d = '0; hs_di_d = '0; hs_ha_d = '0; hs_an_d = '0;
                if (left_d == '0) begin
                  row = '0; row.kind = KIND_DONE; row.brush_number = idx_d;
                  row.version = ver_q; r1 = row; n = 2'd2; fin_d = 1'b1;
                end else ph_d = PH_TAG;
              end
            end
          end
          PH_ANGLE: begin
            capv = cap(v, CapAngle);
            hs_an_d = capv[8:0]; ph_d = PH_ROUND;
          end
          default: ph_d = PH_SKIP;
        endcase
      end
      // End of buffer: close a skipped record or report the missing field.
      if (final_byte_i && !fin_d) begin
        row = '0; row.version = ver_d; row.brush_number = idx_d;
        if (ph_d == PH_SKIP) begin
          left_d = left_d - 16'd1; idx_d = idx_d + 16'd1;
          row.brush_number = idx_d;
          if (left_d == '0) row.kind = KIND_DONE;
          else begin
            row.kind = KIND_ERROR; row.error_code = ERR_EOF_TAG;
          end
        end else begin
          row.kind = KIND_ERROR;
          unique case (ph_d)
            PH_MAGIC:       ecode = ERR_MAGIC;
            PH_VERSION:     ecode = ERR_EOF_VER;
            PH_UNK, PH_COUNT: ecode = ERR_EOF_CNT;
            PH_TAG:         ecode = ERR_EOF_TAG;
            PH_LEN:         ecode = ERR_EOF_LEN;
            default:        ecode = ERR_EOF_BODY;
          endcase
          row.error_code = ecode;
        end
        if (n == 2'd0) begin
          r0 = row; n = 2'd1;
        end else begin
          r1 = row; n = 2'd2;
        end
      end
    end
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
    // Rearm on the final byte of a buffer.
    if (step_i && final_byte_i) begin
      ph_d = PH_MAGIC; cnt_d = '0; sh_d = '0; ver_d = '0; left_d = '0; idx_d = '0;
      len_d = '0; off_d = '0; nul_d = '0; sf_d = 1'b0; fin_d = 1'b0; ctag_d = 1'b0;
      hs_sp_d = '0; hs_di_d = '0; hs_ha_d = '0; hs_an_d = '0;
    end
  end

  assign res0_o = r0;
  assign res1_o = r1;
  assign nres_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_MAGIC; cnt_q <= '0; sh_q <= '0; ver_q <= '0; left_q <= '0;
      idx_q <= '0; nul_q <= '0; len_q <= '0; off_q <= '0; sf_q <= 1'b0;
      fin_q <= 1'b0; ctag_q <= 1'b0; hs_sp_q <= '0; hs_di_q <= '0;
      hs_ha_q <= '0; hs_an_q <= '0;
    end else begin
      ph_q <= ph_d; cnt_q <= cnt_d; sh_q <= sh_d; ver_q <= ver_d; left_q <= left_d;
      idx_q <= idx_d; nul_q <= nul_d; len_q <= len_d; off_q <= off_d; sf_q <= sf_d;
      fin_q <= fin_d; ctag_q <= ctag_d; hs_sp_q <= hs_sp_d; hs_di_q <= hs_di_d;
      hs_ha_q <= hs_ha_d; hs_an_q <= hs_an_d;
    end
  end

endmodule
`default_nettype wire

>>> design/bpsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bpsp_queue
// Result queue; takes up to two entries a cycle, hands out one.
// -----------------------------------------------------------------------------
module bpsp_queue import bpsp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic [1:0] wr_n_i,
  input  result_t    wr0_i,
  input  result_t    wr1_i,
  input  wire logic  rd_i,
  output result_t    rd_o,
  output logic       empty_o,
  output logic       has2_o
);

  localparam int AW = $clog2(QueueDepth);

  result_t         mem_q [QueueDepth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;
  logic [AW-1:0]   wp1;

  assign wp1     = wp_q + AW'(1);
  assign empty_o = (cnt_q == '0);
  assign has2_o  = (cnt_q <= (AW+1)'(QueueDepth - 2));
  assign rd_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_n_i != 2'd0) mem_q[wp_q] <= wr0_i;
    if (wr_n_i == 2'd2) mem_q[wp1]  <= wr1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + AW'(wr_n_i);
      rp_q  <= rp_q + AW'(rd_i);
      cnt_q <= cnt_q + (AW+1)'(wr_n_i) - (AW+1)'(rd_i);
    end
  end

endmodule
`default_nettype wire

>>> design/brush_preset_stream_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// brush_preset_stream_parser_unit
// Byte-stream parser for brush preset files.
// -----------------------------------------------------------------------------
// Usage: push one file byte a cycle on data_byte_i/final_byte_i while full is
// low. The front parser handles each byte in the cycle it is accepted and
// writes zero, one or two results into an eight-entry result queue; results
// are then popped in order through empty/pop. A result is visible in the cycle
// after its byte is accepted. The parser takes one byte per cycle while full
// is low; full rises only when the queue lacks room for two results, i.e.
// while the receiver stalls on pop.
// Configuration writes (index 0 max brush count, 1 max name units) go through
// cfg_valid/cfg_ready and are always taken. Reset empties the queue, restores
// the register defaults and rearms the parser for the magic word.
// -----------------------------------------------------------------------------
module brush_preset_stream_parser_unit import bpsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        final_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       result_kind_o,
  output logic [15:0]      name_unit_o,
  output logic [15:0]      brush_number_o,
  output logic [9:0]       spacing_out_o,
  output logic [10:0]      diameter_out_o,
  output logic [6:0]       hardness_out_o,
  output logic [8:0]       angle_out_o,
  output logic [6:0]       roundness_out_o,
  output logic             long_form_o,
  output logic [3:0]       format_version_o,
  output logic [3:0]       error_code_o,
  output logic             last_result_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0] max_count_q, max_name_q;
  result_t     r0, r1, head;
  logic [1:0]  nres;
  logic        has2, step;

  assign cfg_ready = 1'b1;
  assign full      = !has2;
  assign step      = push && has2;

  // Hold the two limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= MaxCountRst;
      max_name_q  <= MaxNameRst;
    end else if (cfg_valid) begin
      if (cfg_index_i == CfgMaxCount) max_count_q <= cfg_data_i;
      else                            max_name_q  <= cfg_data_i;
    end
  end

  bpsp_front u_front (
    .clk_i, .rst_ni, .step_i(step), .data_byte_i, .final_byte_i,
    .max_count_i(max_count_q), .max_name_i(max_name_q),
    .res0_o(r0), .res1_o(r1), .nres_o(nres)
  );

  bpsp_queue u_queue (
    .clk_i, .rst_ni, .wr_n_i(nres), .wr0_i(r0), .wr1_i(r1),
    .rd_i(pop && !empty), .rd_o(head), .empty_o(empty), .has2_o(has2)
  );

  assign result_kind_o    = head.kind;
  assign name_unit_o      = head.name_unit;
  assign brush_number_o   = head.brush_number;
  assign spacing_out_o    = head.spacing;
  assign diameter_out_o   = head.diameter;
  assign hardness_out_o   = head.hardness;
  assign angle_out_o      = head.angle;
  assign roundness_out_o  = head.roundness;
  assign long_form_o      = head.long_form;
  assign format_version_o = head.version;
  assign error_code_o     = head.error_code;
  assign last_result_o    = head.last;

endmodule
`default_nettype wire

>>> test/tb_brush_preset_stream_parser_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_brush_preset_stream_parser_unit
// Self-checking bench for the brush preset stream parser. Whole brush files
// are built byte by byte, from well-formed ones with random content down to
// broken and cut-off ones, and pushed with random gaps. A cycle-free
// predictor of the parser works out the results of each accepted byte, and
// the monitor compares every popped result field by field against them.
// -----------------------------------------------------------------------------
module tb_brush_preset_stream_parser_unit;
  import bpsp_pkg::*;

  localparam int ClkPeriod = 12;
  localparam int StallLimit = 5000;
  localparam int TargetBytes = 650;

  // Kinds of damage that the file builder can apply on purpose.
  typedef enum int {
    BRK_NONE, BRK_MAGIC, BRK_VERSION, BRK_V9, BRK_COUNT_BIG, BRK_NAME_LEN,
    BRK_OVERREAD, BRK_TRUNCATE
  } file_break_e;

  // Parser phases as the predictor tracks them.
  typedef enum int {
    PH_MAGIC, PH_VERSION, PH_UNK, PH_COUNT, PH_TAG, PH_LEN, PH_UNK1, PH_NAMELEN,
    PH_NAME, PH_SHORT, PH_SPACING, PH_DIAM, PH_HARD, PH_ANGLE, PH_ROUND, PH_SKIP
  } parse_phase_e;

  typedef struct {
    logic [7:0] b;
    logic       f;
  } file_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte_i;
  logic        final_byte_i;
  logic        empty;
  logic        pop;
  logic [1:0]  result_kind_o;
  logic [15:0] name_unit_o;
  logic [15:0] brush_number_o;
  logic [9:0]  spacing_out_o;
  logic [10:0] diameter_out_o;
  logic [6:0]  hardness_out_o;
  logic [8:0]  angle_out_o;
  logic [6:0]  roundness_out_o;
  logic        long_form_o;
  logic [3:0]  format_version_o;
  logic [3:0]  error_code_o;
  logic        last_result_o;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;

  brush_preset_stream_parser_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte_i),
    .final_byte_i     (final_byte_i),
    .empty            (empty),
    .pop              (pop),
    .result_kind_o    (result_kind_o),
    .name_unit_o      (name_unit_o),
    .brush_number_o   (brush_number_o),
    .spacing_out_o    (spacing_out_o),
    .diameter_out_o   (diameter_out_o),
    .hardness_out_o   (hardness_out_o),
    .angle_out_o      (angle_out_o),
    .roundness_out_o  (roundness_out_o),
    .long_form_o      (long_form_o),
    .format_version_o (format_version_o),
    .error_code_o     (error_code_o),
    .last_result_o    (last_result_o),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  file_byte_t   byte_backlog[$];   // bytes waiting for the driver
  logic [7:0]   file_buf[$];       // file under construction
  result_t      expected_results[$];
  result_t      step_results[$];   // results of the byte being predicted
  bit           idle_en;
  int           fail_count;
  int           bytes_sent;
  int           results_seen;
  int           files_built;
  int           push_gap;
  int           pop_gap;
  int           stall_cycles;

  // Configuration as the predictor sees it.
  logic [15:0]  lim_count;
  logic [15:0]  lim_name;

  // Predictor state.
  parse_phase_e phase;
  int unsigned  fld_cnt;
  logic [31:0]  fld_shift;
  logic [3:0]   ver_q;
  logic [15:0]  brushes_left;
  logic [15:0]  brush_idx;
  logic [31:0]  rec_len;
  logic [32:0]  rec_off;
  logic [15:0]  units_left;
  bit           short_q;
  bit           computed_tag;
  logic [9:0]   hs_spacing;
  logic [10:0]  hs_diameter;
  logic [6:0]   hs_hardness;
  logic [8:0]   hs_angle;
  bit           parse_over;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_parse();
    phase = PH_MAGIC;
    fld_cnt = 0;
    fld_shift = '0;
    ver_q = '0;
    brushes_left = '0;
    brush_idx = '0;
    rec_len = '0;
    rec_off = '0;
    units_left = '0;
    short_q = 1'b0;
    computed_tag = 1'b0;
    hs_spacing = '0;
    hs_diameter = '0;
    hs_hardness = '0;
    hs_angle = '0;
    parse_over = 1'b0;
  endfunction

  function automatic result_t blank_result(kind_e kind);
    result_t r;
    r = '0;
    r.kind = kind;
    r.brush_number = brush_idx;
    r.version = ver_q;
    return r;
  endfunction

  // A step never causes more than two results; anything past that is dropped.
  function automatic void add_result(result_t r);
    if (step_results.size() < 2) step_results.push_back(r);
  endfunction

  function automatic void flag_error(err_e code);
    result_t r;
    r = blank_result(KIND_ERROR);
    r.error_code = code;
    add_result(r);
    parse_over = 1'b1;
  endfunction

  function automatic void close_record();
    brushes_left = brushes_left - 16'd1;
    brush_idx = brush_idx + 16'd1;
    computed_tag = 1'b0;
    if (brushes_left == 16'd0) begin
      add_result(blank_result(KIND_DONE));
      parse_over = 1'b1;
    end else begin
      phase = PH_TAG;
    end
  endfunction

  function automatic void emit_preset(logic [31:0] round_v);
    result_t r;
    r = blank_result(KIND_PRESET);
    r.spacing = hs_spacing;
    r.diameter = hs_diameter;
    r.hardness = hs_hardness;
    if (!short_q) begin
      r.angle = hs_angle;
      r.roundness = (round_v > CapPercent) ? CapPercent[6:0] : round_v[6:0];
      r.long_form = 1'b1;
    end
    add_result(r);
    // Overread is judged only once the preset is out.
    if ({1'b0, rec_len} < rec_off) flag_error(ERR_OVERREAD);
    else if ({1'b0, rec_len} > rec_off) phase = PH_SKIP;
    else close_record();
  endfunction

  function automatic void field_complete(logic [31:0] v);
    result_t r;
    case (phase)
      PH_MAGIC: begin
        if (v[15:0] != MagicWord) flag_error(ERR_MAGIC);
        else phase = PH_VERSION;
      end
      PH_VERSION: begin
        if (v[15:0] != 16'd6 && v[15:0] != 16'd7 && v[15:0] != 16'd9) begin
          flag_error(ERR_VERSION);
        end else begin
          ver_q = v[3:0];
          phase = PH_UNK;
        end
      end
      PH_UNK: phase = PH_COUNT;
      PH_COUNT: begin
        if (v > {16'd0, lim_count}) flag_error(ERR_CNT_BIG);
        else if (ver_q == 4'd9) flag_error(ERR_V9);
        else begin
          brushes_left = v[15:0];
          brush_idx = '0;
          if (v == 0) begin
            add_result(blank_result(KIND_DONE));
            parse_over = 1'b1;
          end else begin
            phase = PH_TAG;
          end
        end
      end
      PH_TAG: begin
        computed_tag = (v == TagMHi || v == TagMLo);
        phase = PH_LEN;
      end
      PH_LEN: begin
        rec_len = v;
        rec_off = '0;
        if (computed_tag) phase = PH_UNK1;
        else if (v == 0) close_record();
        else phase = PH_SKIP;
        computed_tag = 1'b0;
      end
      PH_UNK1: phase = PH_NAMELEN;
      PH_NAMELEN: begin
        if (v < 1 || v > {16'd0, lim_name}) flag_error(ERR_NAME_LEN);
        else begin
          units_left = v[15:0];
          phase = PH_NAME;
        end
      end
      PH_NAME: begin
        r = blank_result(KIND_NAME);
        r.name_unit = v[15:0];
        add_result(r);
        units_left = units_left - 16'd1;
        if (units_left == 16'd0) phase = PH_SHORT;
      end
      PH_SHORT: begin
        short_q = (v != 0);
        phase = PH_SPACING;
      end
      PH_SPACING: begin
        hs_spacing = (v > CapSpacing) ? CapSpacing[9:0] : v[9:0];
        phase = PH_DIAM;
      end
      PH_DIAM: begin
        if (v == 0) hs_diameter = 11'd1;
        else hs_diameter = (v > CapDiameter) ? CapDiameter[10:0] : v[10:0];
        phase = PH_HARD;
      end
      PH_HARD: begin
        hs_hardness = (v > CapPercent) ? CapPercent[6:0] : v[6:0];
        hs_angle = '0;
        if (short_q) emit_preset(32'd0);
        else phase = PH_ANGLE;
      end
      PH_ANGLE: begin
        hs_angle = (v > CapAngle) ? CapAngle[8:0] : v[8:0];
        phase = PH_ROUND;
      end
      default: emit_preset(v);
    endcase
  endfunction

  function automatic err_e eof_error();
    case (phase)
      PH_MAGIC:         return ERR_MAGIC;
      PH_VERSION:       return ERR_EOF_VER;
      PH_UNK, PH_COUNT: return ERR_EOF_CNT;
      PH_TAG:           return ERR_EOF_TAG;
      PH_LEN:           return ERR_EOF_LEN;
      default:          return ERR_EOF_BODY;
    endcase
  endfunction

  // Work out the results of one accepted byte and queue them as expected.
  function automatic void parse_byte(logic [7:0] b, logic fin);
    int unsigned need;
    step_results.delete();
    if (!parse_over) begin
      if (phase >= PH_UNK1) rec_off = rec_off + 33'd1;
      if (phase == PH_SKIP) begin
        if (rec_off >= {1'b0, rec_len}) close_record();
      end else begin
        need = (phase == PH_MAGIC || phase == PH_VERSION || phase == PH_NAME) ? 2 : 4;
        fld_shift = {fld_shift[23:0], b};
        if (fld_cnt + 1 < need) begin
          fld_cnt = fld_cnt + 1;
        end else begin
          fld_cnt = 0;
          need = fld_shift;
          fld_shift = '0;
          field_complete(need);
        end
      end
      if (fin && !parse_over) begin
        if (phase == PH_SKIP) close_record();
        if (!parse_over) flag_error(eof_error());
      end
    end
    // A final byte rearms the parser for the next file.
    if (fin) clear_parse();
    foreach (step_results[k]) begin
      step_results[k].last = (k == step_results.size() - 1);
      expected_results.push_back(step_results[k]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // File builder
  // ---------------------------------------------------------------------------
  function automatic void put_be(int nbytes, logic [31:0] v);
    for (int i = nbytes - 1; i >= 0; i--) file_buf.push_back(v[8 * i +: 8]);
  endfunction

  // Setting values that straddle the saturation points.
  function automatic logic [31:0] pick_setting();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return $urandom_range(0, 120);
      2:       return $urandom_range(990, 2010);
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom;
      default: return $urandom_range(350, 365);
    endcase
  endfunction

  function automatic void build_file(file_break_e brk);
    file_byte_t fb;
    logic [31:0] count;
    logic [31:0] rec_body;
    logic [31:0] rec_size;
    int units;
    bit is_long;
    int cut;
    put_be(2, (brk == BRK_MAGIC) ? {16'd0, MagicWord ^ 16'h0100} : {16'd0, MagicWord});
    case (brk)
      BRK_VERSION: put_be(2, $urandom_range(10, 65535));
      BRK_V9:      put_be(2, 32'd9);
      default:     put_be(2, ($urandom_range(0, 15) == 0) ? 32'd9 :
                              ($urandom_range(0, 1) ? 32'd6 : 32'd7));
    endcase
    put_be(4, $urandom);
    if (brk == BRK_COUNT_BIG) count = {16'd0, lim_count} + 32'd1;
    else count = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 3);
    put_be(4, count);
    // Header breaks stop the parse early; records after them would be ignored.
    if (brk == BRK_NONE || brk >= BRK_NAME_LEN) begin
      for (int r = 0; r < count; r++) begin
        if ($urandom_range(0, 3) == 0) begin
          // Foreign record: skipped by length.
          rec_size = $urandom_range(0, 6);
          put_be(4, $urandom);
          put_be(4, rec_size);
          for (int i = 0; i < rec_size; i++) put_be(1, $urandom);
        end else begin
          units = $urandom_range(1, (lim_name < 3) ? lim_name : 3);
          is_long = $urandom_range(0, 1);
          rec_body = 8 + 2 * units + 16 + (is_long ? 8 : 0);
          rec_size = rec_body + $urandom_range(0, 3);
          if (brk == BRK_OVERREAD && r == 0) rec_size = rec_body - $urandom_range(1, 3);
          put_be(4, $urandom_range(0, 1) ? TagMHi : TagMLo);
          put_be(4, rec_size);
          put_be(4, $urandom);
          if (brk == BRK_NAME_LEN && r == 0) begin
            put_be(4, $urandom_range(0, 1) ? 32'd0 : {16'd0, lim_name} + 32'd1);
          end else begin
            put_be(4, units);
            for (int i = 0; i < units; i++) put_be(2, $urandom);
            put_be(4, is_long ? 32'd0 : (pick_setting() | 32'd1));
            put_be(4, pick_setting());
            put_be(4, pick_setting());
            put_be(4, pick_setting());
            if (is_long) begin
              put_be(4, pick_setting());
              put_be(4, pick_setting());
            end
            for (int i = rec_body; i < rec_size; i++) put_be(1, $urandom);
          end
        end
      end
    end
    // Cut the buffer short, or pad it with bytes the parser must ignore.
    if (brk == BRK_TRUNCATE) begin
      cut = $urandom_range(1, file_buf.size());
      while (file_buf.size() > cut) void'(file_buf.pop_back());
    end else if ($urandom_range(0, 7) == 0) begin
      for (int i = $urandom_range(1, 4); i > 0; i--) put_be(1, $urandom);
    end
    foreach (file_buf[i]) begin
      fb.b = file_buf[i];
      fb.f = (i == file_buf.size() - 1);
      byte_backlog.push_back(fb);
    end
    file_buf.delete();
    files_built++;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver: hold while full, advance on each accepted transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        parse_byte(data_byte_i, final_byte_i);
        bytes_sent++;
      end
      if (!(push && full)) begin
        if (push_gap > 0) begin
          push_gap--;
          push <= 1'b0;
        end else if (idle_en && $urandom_range(0, 11) == 0) begin
          push_gap = $urandom_range(0, 17);
          push <= 1'b0;
        end else if (byte_backlog.size() > 0) begin
          push <= 1'b1;
          data_byte_i <= byte_backlog[0].b;
          final_byte_i <= byte_backlog[0].f;
          void'(byte_backlog.pop_front());
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each popped transaction with the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, kind %0d", $time, result_kind_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.kind, result_kind_o);
          check_field("name_unit", want.name_unit, name_unit_o);
          check_field("brush_number", want.brush_number, brush_number_o);
          check_field("spacing_out", want.spacing, spacing_out_o);
          check_field("diameter_out", want.diameter, diameter_out_o);
          check_field("hardness_out", want.hardness, hardness_out_o);
          check_field("angle_out", want.angle, angle_out_o);
          check_field("roundness_out", want.roundness, roundness_out_o);
          check_field("long_form", want.long_form, long_form_o);
          check_field("format_version", want.version, format_version_o);
          check_field("error_code", want.error_code, error_code_o);
          check_field("last_result", want.last, last_result_o);
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        pop_gap = $urandom_range(0, 17);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transaction ends the run.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CfgMaxCount) lim_count = value;
    else lim_name = value;
    cfg_valid <= 1'b0;
  endtask

  // Hold until every byte went in and every result came out, then let the
  // bench idle with no bytes pushed.
  task automatic drain();
    do @(posedge clk_i);
    while (byte_backlog.size() > 0 || push || expected_results.size() > 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic random_files(int byte_goal);
    int start;
    start = bytes_sent + byte_backlog.size();
    while (bytes_sent + byte_backlog.size() - start < byte_goal) begin
      case ($urandom_range(0, 15))
        0:       build_file(BRK_TRUNCATE);
        1:       build_file(BRK_TRUNCATE);
        2:       build_file(BRK_OVERREAD);
        3:       build_file(BRK_NAME_LEN);
        4:       build_file(file_break_e'($urandom_range(BRK_MAGIC, BRK_COUNT_BIG)));
        default: build_file(BRK_NONE);
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    data_byte_i = '0;
    final_byte_i = 1'b0;
    cfg_valid = 1'b0;
    cfg_index_i = CfgMaxCount;
    cfg_data_i = '0;
    idle_en = 1'b1;
    fail_count = 0;
    bytes_sent = 0;
    results_seen = 0;
    files_built = 0;
    push_gap = 0;
    pop_gap = 0;
    stall_cycles = 0;
    lim_count = MaxCountRst;
    lim_name = MaxNameRst;
    clear_parse();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: one clean file, then one of each header and record failure and a cut-off file.
    build_file(BRK_NONE);
    build_file(BRK_MAGIC);
    build_file(BRK_VERSION);
    build_file(BRK_V9);
    build_file(BRK_COUNT_BIG);
    build_file(BRK_NAME_LEN);
    build_file(BRK_OVERREAD);
    build_file(BRK_TRUNCATE);
    drain();

    // Tightest limits: any nonzero count and any name past one unit fail.
    write_reg(CfgMaxCount, 16'd0);
    write_reg(CfgMaxName, 16'd1);
    random_files(50);
    drain();

    write_reg(CfgMaxCount, 16'd2);
    random_files(60);
    drain();

    write_reg(CfgMaxCount, 16'hFFFF);
    write_reg(CfgMaxName, 16'hFFFF);
    random_files(60);
    drain();

    write_reg(CfgMaxCount, $urandom_range(1, 4));
    write_reg(CfgMaxName, $urandom_range(2, 3));
    random_files(60);
    drain();

    // Closing stretch at full rate on both sides.
    idle_en = 1'b0;
    write_reg(CfgMaxCount, MaxCountRst);
    write_reg(CfgMaxName, MaxNameRst);
    random_files((TargetBytes - bytes_sent > 40) ? TargetBytes - bytes_sent : 40);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d files in %0d bytes, %0d results checked, six limit settings.",
             files_built, bytes_sent, results_seen);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", fail_count,
               expected_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> brush_preset_stream_parser_unit.f
design/bpsp_pkg.sv
design/bpsp_front.sv
design/bpsp_queue.sv
design/brush_preset_stream_parser_unit.sv
test/tb_brush_preset_stream_parser_unit.sv
